FILE: src/fstm_pkg.sv
package fstm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TUNE_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SILENT_COUNT  = 3'd5;

    localparam logic [16:0] AMP_FULL  = 17'd65536;
    localparam logic [15:0] DECAY_Q16 = 16'd64225;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_START  = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SYNC   = 2'd1,
        MODE_ACTIVE = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_PHASE,
        ST_MULT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [6:0] tone_index;
        logic [2:0] tone_value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        mode_t              mode;
    } out_item_t;

    typedef struct packed {
        logic [15:0] symbol_length;
        logic [31:0] base_step;
        logic [31:0] tone_step;
        logic [9:0]  ramp_length;
        logic        tune_mode;
        logic [23:0] silent_count;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        symbol_length: 16'd1920,
        base_step:     32'd0,
        tone_step:     32'd2236962,
        ramp_length:   10'd33,
        tune_mode:     1'b0,
        silent_count:  24'd0
    };

    typedef struct packed {
        logic accept;
        logic step_en;
        logic phase_en;
        logic mult_en;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic heavy;
    } dp_status_t;

    // Q15 sine of k/2^(bits-2) * pi/2, Q30 odd Taylor series to x^13
    function automatic logic [14:0] quarter_sine(input int unsigned k,
                                                 input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = ((64'(k) * HALF_PI_Q30) + (64'd1 << (bits - 3))) >> (bits - 2);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

endpackage

FILE: src/fsk_symbol_tone_modulator.sv
// Continuous-phase 8-tone FSK audio generator.
// Input channel (s_valid/s_ready/s_data) takes one request at a time:
// load tone, start, sample request or stop. Every request yields exactly
// one result on m_valid/m_ready/m_data: the audio sample (zero for all but
// a sample request while transmitting) and the run mode after the request.
// A sample request that produces a tone passes, after the accept, through the
// phase step, the phase add with decay multiply and sine lookup, the amplitude
// multiply and the output load; the tone table is read at the accept itself.
// All other requests go from the accept straight to the output load.
// One request is in flight at a time: a new request is not accepted until the
// current one has been loaded into the output register.
// The result sits in an output register; a new request is accepted while it
// waits. If the receiver stalls, the next result is held back and no further
// request is accepted until the output register frees.
// Configuration (cfg_wr_en/cfg_index/cfg_data) is to be written only while idle; the block does not enforce this.
// Reset restores the register defaults, idle mode, full amplitude and zero
// phase; the tone table holds no defined contents until loaded.
module fsk_symbol_tone_modulator #(
    parameter int NUM_SYMBOLS     = 79,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fstm_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output fstm_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [fstm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fstm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    fstm_pkg::cfg_t      cfg_reg, cfg_next;
    fstm_pkg::ctrl_cmd_t cmd;
    fstm_pkg::dp_status_t status;
    logic                m_valid_reg, m_valid_next;
    fstm_pkg::out_item_t m_data_reg;
    logic                out_free;
    logic signed [15:0]  res_sample;
    fstm_pkg::mode_t     res_mode;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                fstm_pkg::REG_SYMBOL_LENGTH: cfg_next.symbol_length = cfg_data[15:0];
                fstm_pkg::REG_BASE_STEP:     cfg_next.base_step     = cfg_data;
                fstm_pkg::REG_TONE_STEP:     cfg_next.tone_step     = cfg_data;
                fstm_pkg::REG_RAMP_LENGTH:   cfg_next.ramp_length   = cfg_data[9:0];
                fstm_pkg::REG_TUNE_MODE:     cfg_next.tune_mode     = cfg_data[0];
                fstm_pkg::REG_SILENT_COUNT:  cfg_next.silent_count  = cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= fstm_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    fstm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    fstm_datapath #(
        .NUM_SYMBOLS     (NUM_SYMBOLS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_data     (s_data),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .status     (status),
        .res_sample (res_sample),
        .res_mode   (res_mode)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg.sample <= res_sample;
            m_data_reg.mode   <= res_mode;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: src/fstm_sine_rom.sv
module fstm_sine_rom #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [SINE_TABLE_BITS-2:0] rd_addr,
    output logic [14:0]                rd_data_reg
);

    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);

    // first quarter wave plus the peak entry
    logic [14:0] rom [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
        assign rom[g] = fstm_pkg::quarter_sine(g, SINE_TABLE_BITS);
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rom[rd_addr];
        end
    end

endmodule

FILE: src/fstm_ctrl.sv
module fstm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   out_free,
    input  fstm_pkg::dp_status_t   status,
    output fstm_pkg::ctrl_cmd_t    cmd
);

    fstm_pkg::state_t state_reg;
    fstm_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fstm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fstm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.heavy ? fstm_pkg::ST_STEP : fstm_pkg::ST_EMIT;
                end
            end
            fstm_pkg::ST_STEP:  state_next = fstm_pkg::ST_PHASE;
            fstm_pkg::ST_PHASE: state_next = fstm_pkg::ST_MULT;
            fstm_pkg::ST_MULT:  state_next = fstm_pkg::ST_EMIT;
            fstm_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = fstm_pkg::ST_IDLE;
                end
            end
            default: state_next = fstm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            fstm_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            fstm_pkg::ST_STEP:  cmd.step_en  = 1'b1;
            fstm_pkg::ST_PHASE: cmd.phase_en = 1'b1;
            fstm_pkg::ST_MULT:  cmd.mult_en  = 1'b1;
            fstm_pkg::ST_EMIT:  cmd.load_out = out_free;
            default: ;
        endcase
    end

endmodule

FILE: src/fstm_datapath.sv
module fstm_datapath #(
    parameter int NUM_SYMBOLS     = 79,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  fstm_pkg::in_item_t          s_data,
    input  fstm_pkg::cfg_t              cfg,
    input  fstm_pkg::ctrl_cmd_t         cmd,
    output fstm_pkg::dp_status_t        status,
    output logic signed [15:0]          res_sample,
    output fstm_pkg::mode_t             res_mode
);

    localparam int SYM_W   = $clog2(NUM_SYMBOLS + 1);
    localparam int TAB_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int B       = SINE_TABLE_BITS;
    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam int REM_W   = SYM_W + 16;

    logic [2:0] tone_mem [NUM_SYMBOLS];

    fstm_pkg::mode_t    run_mode_reg, run_mode_next;
    logic [23:0]        silence_reg, silence_next;
    logic [15:0]        sis_reg, sis_next;
    logic [SYM_W-1:0]   symnum_reg, symnum_next;
    logic [31:0]        phase_reg, phase_next;
    logic [16:0]        amp_reg, amp_next;
    logic [31:0]        step_reg, step_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               in_ramp_reg, in_ramp_next;
    logic               neg_reg, neg_next;
    logic signed [15:0] res_sample_reg, res_sample_next;
    logic [2:0]         tone_rd_reg;

    logic [SYM_W-1:0]   sym_left;
    logic [31:0]        phase_sum;
    logic [B-1:0]       sine_idx;
    logic [B-2:0]       rom_addr;
    logic [14:0]        rom_data;
    logic [32:0]        decay_prod;
    logic [31:0]        samp_prod;
    logic [14:0]        mag;
    logic [16:0]        sis_inc;
    logic signed [REM_W:0] ramp_left;
    logic [TAB_W-1:0]   tone_rd_addr;
    logic               tone_wr_en;

    assign tone_rd_addr = cfg.tune_mode ? '0 : symnum_reg[TAB_W-1:0];
    assign tone_wr_en   = cmd.accept && (s_data.cmd == fstm_pkg::CMD_LOAD)
                          && ({1'b0, s_data.tone_index} < 8'(NUM_SYMBOLS));

    always_ff @(posedge aclk) begin
        if (tone_wr_en) begin
            tone_mem[s_data.tone_index[TAB_W-1:0]] <= s_data.tone_value;
        end
        if (cmd.accept) begin
            tone_rd_reg <= tone_mem[tone_rd_addr];
        end
    end

    assign status.heavy = (s_data.cmd == fstm_pkg::CMD_SAMPLE)
        && ((run_mode_reg == fstm_pkg::MODE_ACTIVE)
            || ((run_mode_reg == fstm_pkg::MODE_SYNC) && (silence_reg == '0)))
        && (cfg.tune_mode || (symnum_reg < SYM_W'(NUM_SYMBOLS)));

    fstm_sine_rom #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_sine_rom (
        .aclk        (aclk),
        .rd_en       (cmd.phase_en),
        .rd_addr     (rom_addr),
        .rd_data_reg (rom_data)
    );

    always_comb begin
        run_mode_next   = run_mode_reg;
        silence_next    = silence_reg;
        sis_next        = sis_reg;
        symnum_next     = symnum_reg;
        phase_next      = phase_reg;
        amp_next        = amp_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        in_ramp_next    = in_ramp_reg;
        neg_next        = neg_reg;
        res_sample_next = res_sample_reg;

        sym_left   = SYM_W'(NUM_SYMBOLS) - symnum_reg;
        phase_sum  = phase_reg + step_reg;
        sine_idx   = phase_sum[31 -: B];
        rom_addr   = sine_idx[B-2] ? ((B-1)'(QUARTER) - {1'b0, sine_idx[B-3:0]})
                                   : {1'b0, sine_idx[B-3:0]};
        decay_prod = {16'd0, amp_reg} * {17'd0, fstm_pkg::DECAY_Q16};
        samp_prod  = {15'd0, amp_reg} * {17'd0, rom_data};
        mag        = samp_prod[30:16];
        sis_inc    = {1'b0, sis_reg} + 17'd1;
        ramp_left  = $signed({1'b0, rem_reg}) - $signed({{(SYM_W + 1){1'b0}}, sis_reg});

        if (cmd.accept) begin
            res_sample_next = '0;
            // samples left to the end, before subtracting the position in symbol
            rem_next = {16'd0, sym_left} * {{SYM_W{1'b0}}, cfg.symbol_length};
            unique case (s_data.cmd)
                fstm_pkg::CMD_LOAD: ;
                fstm_pkg::CMD_START: begin
                    run_mode_next = fstm_pkg::MODE_IDLE;
                    silence_next  = '0;
                    sis_next      = '0;
                    symnum_next   = '0;
                    phase_next    = '0;
                    if (cfg.symbol_length != '0) begin
                        amp_next = fstm_pkg::AMP_FULL;
                        if (!cfg.tune_mode && (cfg.silent_count != '0)) begin
                            silence_next  = cfg.silent_count;
                            run_mode_next = fstm_pkg::MODE_SYNC;
                        end else begin
                            run_mode_next = fstm_pkg::MODE_ACTIVE;
                        end
                    end
                end
                fstm_pkg::CMD_SAMPLE: begin
                    if ((run_mode_reg == fstm_pkg::MODE_SYNC) && (silence_reg != '0)) begin
                        silence_next = silence_reg - 24'd1;
                        if (silence_reg == 24'd1) begin
                            run_mode_next = fstm_pkg::MODE_ACTIVE;
                        end
                    end else if ((run_mode_reg == fstm_pkg::MODE_SYNC)
                                 || (run_mode_reg == fstm_pkg::MODE_ACTIVE)) begin
                        run_mode_next = fstm_pkg::MODE_ACTIVE;
                        if (!cfg.tune_mode && (symnum_reg >= SYM_W'(NUM_SYMBOLS))) begin
                            run_mode_next = fstm_pkg::MODE_IDLE;
                            phase_next    = '0;
                        end
                    end
                end
                fstm_pkg::CMD_STOP: begin
                    run_mode_next = fstm_pkg::MODE_IDLE;
                    silence_next  = '0;
                    sis_next      = '0;
                    symnum_next   = '0;
                    phase_next    = '0;
                end
                default: ;
            endcase
        end

        if (cmd.step_en) begin
            step_next    = cfg.base_step + (cfg.tone_step * {29'd0, tone_rd_reg});
            in_ramp_next = !cfg.tune_mode
                && (ramp_left < $signed({{(REM_W - 9){1'b0}}, cfg.ramp_length}));
        end

        if (cmd.phase_en) begin
            phase_next = phase_sum;
            neg_next   = sine_idx[B-1];
            if (in_ramp_reg) begin
                amp_next = decay_prod[32:16];
            end
        end

        if (cmd.mult_en) begin
            res_sample_next = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            if (!cfg.tune_mode) begin
                if (sis_inc >= {1'b0, cfg.symbol_length}) begin
                    sis_next    = '0;
                    symnum_next = symnum_reg + 1'b1;
                end else begin
                    sis_next = sis_inc[15:0];
                end
            end
            if (amp_reg == '0) begin
                run_mode_next = fstm_pkg::MODE_IDLE;
                phase_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_mode_reg <= fstm_pkg::MODE_IDLE;
            silence_reg  <= '0;
            sis_reg      <= '0;
            symnum_reg   <= '0;
            phase_reg    <= '0;
            amp_reg      <= fstm_pkg::AMP_FULL;
        end else begin
            run_mode_reg <= run_mode_next;
            silence_reg  <= silence_next;
            sis_reg      <= sis_next;
            symnum_reg   <= symnum_next;
            phase_reg    <= phase_next;
            amp_reg      <= amp_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg       <= step_next;
        rem_reg        <= rem_next;
        in_ramp_reg    <= in_ramp_next;
        neg_reg        <= neg_next;
        res_sample_reg <= res_sample_next;
    end

    assign res_sample = res_sample_reg;
    assign res_mode   = run_mode_reg;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int NUM_SYM     = 79;
    localparam int SINE_BITS   = 10;
    localparam int SINE_SIZE   = 1 << SINE_BITS;
    localparam int QUARTER     = 1 << (SINE_BITS - 2);
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 40;
    localparam int HOLD_CYCLES = 250;

    localparam logic [fstm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [fstm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    fstm_pkg::in_item_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    fstm_pkg::out_item_t             m_data;
    logic                            cfg_wr_en = 1'b0;
    logic [fstm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fstm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    fsk_symbol_tone_modulator #(
        .NUM_SYMBOLS     (NUM_SYM),
        .SINE_TABLE_BITS (SINE_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // generator state
    fstm_pkg::in_item_t  req_backlog[$];
    fstm_pkg::out_item_t samples_due[$];
    fstm_pkg::out_item_t want;

    int errors        = 0;
    int reports       = 0;
    int cycle_count   = 0;
    int reqs_sent     = 0;
    int results_seen  = 0;
    int audible       = 0;
    int fades         = 0;
    int settings_used = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    // modulator model state
    logic signed [15:0] sine_lut [SINE_SIZE];
    logic [2:0]         tone_mem [NUM_SYM];
    fstm_pkg::cfg_t     tx_cfg    = fstm_pkg::CFG_RESET;
    fstm_pkg::mode_t    tx_mode   = fstm_pkg::MODE_IDLE;
    logic [23:0]        silence_q = '0;
    logic [15:0]        pos_in_sym = '0;
    logic [6:0]         sym_no    = '0;
    logic [31:0]        acc_phase = '0;
    logic [31:0]        acc_step  = '0;
    logic [16:0]        amp_q16   = fstm_pkg::AMP_FULL;

    // Q15 sine over the first quadrant, Q30 odd series to x^13
    function automatic int quarter_q15(int unsigned k);
        longint unsigned denom [6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned x, x2, t, s, v;
        x  = (64'(k) * fstm_pkg::HALF_PI_Q30 + 64'(QUARTER / 2)) / 64'(QUARTER);
        x2 = (x * x) >> 30;
        t  = fstm_pkg::Q30_ONE;
        for (int i = 0; i < 6; i++) begin
            t = fstm_pkg::Q30_ONE - ((x2 * t) >> 30) / denom[i];
        end
        s = (x * t) >> 30;
        v = (s * 64'd32767 + (fstm_pkg::Q30_ONE >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return int'(v);
    endfunction

    initial begin
        int q, k, v;
        for (int i = 0; i < SINE_SIZE; i++) begin
            q = i >> (SINE_BITS - 2);
            k = i & (QUARTER - 1);
            v = (q & 1) ? quarter_q15(QUARTER - k) : quarter_q15(k);
            sine_lut[i] = 16'((q & 2) ? -v : v);
        end
    end

    function automatic void clear_run();
        tx_mode    = fstm_pkg::MODE_IDLE;
        silence_q  = '0;
        pos_in_sym = '0;
        sym_no     = '0;
        acc_phase  = '0;
    endfunction

    task automatic modulate(input fstm_pkg::in_item_t req);
        fstm_pkg::out_item_t res;
        logic [31:0]         tone;
        longint              total, done;
        int                  wave, mag, scaled;
        res.sample = '0;
        case (req.cmd)
            fstm_pkg::CMD_LOAD: begin
                if (req.tone_index < NUM_SYM) begin
                    tone_mem[req.tone_index] = req.tone_value;
                end
            end
            fstm_pkg::CMD_START: begin
                clear_run();
                if (tx_cfg.symbol_length != 0) begin
                    amp_q16   = fstm_pkg::AMP_FULL;
                    acc_step  = '0;
                    silence_q = tx_cfg.tune_mode ? '0 : tx_cfg.silent_count;
                    tx_mode   = (silence_q != 0) ? fstm_pkg::MODE_SYNC : fstm_pkg::MODE_ACTIVE;
                end
            end
            fstm_pkg::CMD_SAMPLE: begin
                if (tx_mode == fstm_pkg::MODE_SYNC && silence_q != 0) begin
                    silence_q = silence_q - 1'b1;
                    if (silence_q == 0) begin
                        tx_mode = fstm_pkg::MODE_ACTIVE;
                    end
                end else if (tx_mode != fstm_pkg::MODE_IDLE) begin
                    tx_mode = fstm_pkg::MODE_ACTIVE;
                    if (!tx_cfg.tune_mode && sym_no >= NUM_SYM) begin
                        tx_mode   = fstm_pkg::MODE_IDLE;
                        acc_phase = '0;
                    end else begin
                        tone      = tone_mem[tx_cfg.tune_mode ? 7'd0 : sym_no];
                        acc_step  = tx_cfg.base_step + tone * tx_cfg.tone_step;
                        acc_phase = acc_phase + acc_step;
                        if (!tx_cfg.tune_mode) begin
                            total = NUM_SYM * longint'(tx_cfg.symbol_length);
                            done  = longint'(sym_no) * longint'(tx_cfg.symbol_length)
                                    + longint'(pos_in_sym);
                            if (total - done < longint'(tx_cfg.ramp_length)) begin
                                amp_q16 = 17'((64'(amp_q16) * 64'(fstm_pkg::DECAY_Q16)) >> 16);
                            end
                        end
                        wave   = sine_lut[acc_phase[31 -: SINE_BITS]];
                        mag    = (wave < 0) ? -wave : wave;
                        scaled = int'((64'(amp_q16) * 64'(mag)) >> 16);
                        res.sample = 16'((wave < 0) ? -scaled : scaled);
                        if (!tx_cfg.tune_mode) begin
                            pos_in_sym = pos_in_sym + 1'b1;
                            if (pos_in_sym >= tx_cfg.symbol_length) begin
                                pos_in_sym = '0;
                                sym_no     = sym_no + 1'b1;
                            end
                        end
                        if (amp_q16 == 0) begin
                            tx_mode   = fstm_pkg::MODE_IDLE;
                            acc_phase = '0;
                            fades++;
                        end
                    end
                end
            end
            fstm_pkg::CMD_STOP: begin
                clear_run();
            end
        endcase
        res.mode = tx_mode;
        samples_due.push_back(res);
    endtask

    // request side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                modulate(s_data);
                reqs_sent++;
            end
            if (!s_valid || s_ready) begin
                if (req_backlog.size() != 0 &&
                    ((reqs_sent >= 700 && reqs_sent < 1000) || $urandom_range(0, 99) >= 14)) begin
                    s_data  <= req_backlog.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (results_seen >= 300 && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (samples_due.size() == 0) begin
                    errors++;
                    if (reports++ < MAX_REPORTS) begin
                        $display("%0t: unexpected result, expected none, got sample %0d mode %0d",
                                 $time, m_data.sample, m_data.mode);
                    end
                end else begin
                    want = samples_due.pop_front();
                    if (m_data.sample !== want.sample) begin
                        errors++;
                        if (reports++ < MAX_REPORTS) begin
                            $display("%0t: sample mismatch, expected %0d, got %0d",
                                     $time, want.sample, m_data.sample);
                        end
                    end
                    if (m_data.mode !== want.mode) begin
                        errors++;
                        if (reports++ < MAX_REPORTS) begin
                            $display("%0t: mode mismatch, expected %0d, got %0d",
                                     $time, want.mode, m_data.mode);
                        end
                    end
                    if (m_data.sample != 0) begin
                        audible++;
                    end
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= (results_seen >= 700 && results_seen < 1000) ||
                           $urandom_range(0, 99) >= 14;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, samples_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void push_cmd(fstm_pkg::cmd_t c);
        fstm_pkg::in_item_t it;
        it.cmd        = c;
        it.tone_index = 7'($urandom_range(0, 127));
        it.tone_value = 3'($urandom_range(0, 7));
        req_backlog.push_back(it);
    endfunction

    function automatic void push_load(int idx, int val);
        fstm_pkg::in_item_t it;
        it.cmd        = fstm_pkg::CMD_LOAD;
        it.tone_index = 7'(idx);
        it.tone_value = 3'(val);
        req_backlog.push_back(it);
    endfunction

    function automatic fstm_pkg::cfg_t make_cfg(int sl, logic [31:0] base, logic [31:0] step,
                                                int ramp, bit tune, int silent);
        fstm_pkg::cfg_t c;
        c.symbol_length = 16'(sl);
        c.base_step     = base;
        c.tone_step     = step;
        c.ramp_length   = 10'(ramp);
        c.tune_mode     = tune;
        c.silent_count  = 24'(silent);
        return c;
    endfunction

    task automatic write_reg(input logic [fstm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fstm_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic apply_config(input fstm_pkg::cfg_t c);
        write_reg(fstm_pkg::REG_SYMBOL_LENGTH, 32'(c.symbol_length));
        write_reg(fstm_pkg::REG_BASE_STEP, c.base_step);
        write_reg(fstm_pkg::REG_TONE_STEP, c.tone_step);
        write_reg(fstm_pkg::REG_RAMP_LENGTH, 32'(c.ramp_length));
        write_reg(fstm_pkg::REG_TUNE_MODE, 32'(c.tune_mode));
        write_reg(fstm_pkg::REG_SILENT_COUNT, 32'(c.silent_count));
        // indexes past the register file must be ignored
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tx_cfg = c;
        settings_used++;
    endtask

    task automatic drain();
        while (req_backlog.size() != 0 || s_valid || samples_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // mostly whole transmissions with random content, some noise in between
    task automatic make_traffic(input int budget);
        int left, span, n;
        left = budget;
        while (left > 0) begin
            if ($urandom_range(0, 99) < 82) begin
                repeat ($urandom_range(0, 3)) begin
                    push_load($urandom_range(0, NUM_SYM - 1), $urandom_range(0, 7));
                    left--;
                end
                push_cmd(fstm_pkg::CMD_START);
                left--;
                span = tx_cfg.tune_mode ? 40 :
                       NUM_SYM * int'(tx_cfg.symbol_length) + int'(tx_cfg.silent_count) + 3;
                if (span > left) begin
                    span = left;
                end
                if (span < 1) begin
                    span = 1;
                end
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span) : span;
                repeat (n) begin
                    if ($urandom_range(0, 29) == 0) begin
                        push_load($urandom_range(0, NUM_SYM - 1), $urandom_range(0, 7));
                    end else begin
                        push_cmd(fstm_pkg::CMD_SAMPLE);
                    end
                end
                left -= n;
                if ($urandom_range(0, 2) == 0) begin
                    push_cmd(fstm_pkg::CMD_STOP);
                    left--;
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    push_cmd(fstm_pkg::cmd_t'($urandom_range(0, 3)));
                    left--;
                end
            end
        end
    endtask

    task automatic run_phase(input fstm_pkg::cfg_t c, input int budget);
        apply_config(c);
        make_traffic(budget);
        drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // every tone slot written before any transmission reads it
        for (int i = 0; i < NUM_SYM; i++) begin
            push_load(i, $urandom_range(0, 7));
        end

        // idle behaviour, table edges and out-of-range slots, restarts
        push_cmd(fstm_pkg::CMD_SAMPLE);
        push_cmd(fstm_pkg::CMD_STOP);
        push_load(0, 7);
        push_load(NUM_SYM - 1, 0);
        push_load(NUM_SYM, 5);
        push_load(127, 7);
        push_cmd(fstm_pkg::CMD_START);
        repeat (3) push_cmd(fstm_pkg::CMD_SAMPLE);
        push_load(0, 3);
        push_cmd(fstm_pkg::CMD_SAMPLE);
        push_cmd(fstm_pkg::CMD_START);
        push_cmd(fstm_pkg::CMD_SAMPLE);
        push_cmd(fstm_pkg::CMD_STOP);
        drain();

        // zero symbol length: start behaves as stop
        apply_config(make_cfg(0, 32'h1234_5678, 32'h0001_0000, 33, 1'b0, 0));
        push_cmd(fstm_pkg::CMD_START);
        push_cmd(fstm_pkg::CMD_SAMPLE);
        drain();

        // tune mode skips the silence
        apply_config(make_cfg(1, 32'h0100_0000, 32'h0040_0000, 5, 1'b1, 5));
        push_cmd(fstm_pkg::CMD_START);
        repeat (3) push_cmd(fstm_pkg::CMD_SAMPLE);
        push_cmd(fstm_pkg::CMD_STOP);
        drain();

        // short silence then into tone
        apply_config(make_cfg(1, $urandom, $urandom, 0, 1'b0, 3));
        push_cmd(fstm_pkg::CMD_START);
        repeat (4) push_cmd(fstm_pkg::CMD_SAMPLE);
        drain();

        run_phase(make_cfg(1, $urandom, $urandom, 0, 1'b0, 0), 220);
        run_phase(make_cfg(3, 32'h0, $urandom, 1023, 1'b0, 2), 260);
        // long ramp on a long message: amplitude decays right down to zero
        run_phase(make_cfg(13, $urandom, $urandom, 1023, 1'b0, 0), 480);
        run_phase(make_cfg(65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 1023),
                           1'b0, 16777215), 60);
        run_phase(make_cfg(2, $urandom, $urandom, 10, 1'b1, $urandom_range(0, 9)), 120);
        run_phase(make_cfg($urandom_range(1, 4), $urandom, $urandom, $urandom_range(0, 300),
                           1'b0, $urandom_range(0, 6)), 180);
        run_phase(make_cfg(65535, $urandom, 32'h0, 33, 1'b0, 0), 80);
        run_phase(make_cfg(1920, 32'h0, 32'h0, 33, 1'b1, 0), 40);

        drain();
        repeat (10) @(posedge aclk);
        $display("Covered %0d requests across %0d register settings:", reqs_sent, settings_used);
        $display("%0d audible samples, %0d fades, result port held off %0d cycles once.",
                 audible, fades, HOLD_CYCLES);
        if (errors == 0 && samples_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
